// ===== rtl/isl_pkg.sv =====
// Shared types and constants for the indexed shift list.
package isl_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    localparam int FUNC_W = 2;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 5;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;
    localparam logic [POS_W-1:0] NO_POS    = 5'h1F;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH   = 2'd0,
        FN_INSERT = 2'd1,
        FN_DELETE = 2'd2,
        FN_FIND   = 2'd3
    } t_func;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } t_state;

    typedef enum logic [2:0] {
        ACT_IDLE,
        ACT_CMP_FIND,
        ACT_CMP_POS,
        ACT_PUSH,
        ACT_INSERT,
        ACT_DELETE
    } t_cell_act;

endpackage

// ===== rtl/isl_in_if.sv =====
// Operation channel: one word per list operation.
interface isl_in_if;
    logic                        valid;
    logic                        ready;
    logic [isl_pkg::FUNC_W-1:0]  func;
    logic [isl_pkg::POS_W-1:0]   position;
    logic [isl_pkg::VAL_W-1:0]   value_in;

    modport source (output valid, func, position, value_in, input ready);
    modport sink   (input valid, func, position, value_in, output ready);
endinterface

// ===== rtl/isl_out_if.sv =====
// Result channel: one word per list operation.
interface isl_out_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic [isl_pkg::VAL_W-1:0]         value_out;
    logic signed [isl_pkg::POS_W-1:0]  found_at;
    logic [isl_pkg::CNT_W-1:0]         count;

    modport source (output valid, ok, value_out, found_at, count, input ready);
    modport sink   (input valid, ok, value_out, found_at, count, output ready);
endinterface

// ===== rtl/isl_cell.sv =====
// One list slot: holds an element, shifts with its neighbors and flags a hit.
module isl_cell #(
    parameter int CW         = 5,
    parameter int ELEM_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  isl_pkg::t_cell_act     i_act,
    input  logic [CW-1:0]          i_pos,
    input  logic [CW-1:0]          i_len,
    input  logic [ELEM_WIDTH-1:0]  i_value,
    input  logic [ELEM_WIDTH-1:0]  i_left,
    input  logic [ELEM_WIDTH-1:0]  i_right,
    output logic [ELEM_WIDTH-1:0]  o_data,
    output logic                   o_hit
);

    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

    logic [ELEM_WIDTH-1:0] r_data;
    logic [ELEM_WIDTH-1:0] n_data;
    logic                  r_hit;
    logic                  n_hit;

    always_comb begin
        n_data = r_data;
        n_hit  = r_hit;
        case (i_act)
            isl_pkg::ACT_CMP_FIND: begin
                n_hit = (MY_IDX < i_len) && (r_data == i_value);
            end
            isl_pkg::ACT_CMP_POS: begin
                n_hit = (MY_IDX < i_len) && (MY_IDX == i_pos);
            end
            isl_pkg::ACT_PUSH: begin
                if (MY_IDX == i_len) begin
                    n_data = i_value;
                end
            end
            isl_pkg::ACT_INSERT: begin
                if (MY_IDX == i_pos) begin
                    n_data = i_value;
                end else if (MY_IDX > i_pos && MY_IDX <= i_len) begin
                    n_data = i_left;
                end
            end
            isl_pkg::ACT_DELETE: begin
                if (MY_IDX >= i_pos && MY_NEXT < i_len) begin
                    n_data = i_right;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

// ===== rtl/indexed_shift_list.sv =====
// Top level of the indexed shift list: control, length and the row of slot cells.
//
//  channel  | dir | payload                              | handshake
//  i_in     | in  | func, position, value_in             | valid / ready
//  o_out    | out | ok, value_out, found_at, count       | valid / ready
//  i_cfg_*  | in  | capacity_limit (5 bits)              | write enable only
//
// Each word passes a compare step and an apply step: at the accepting edge every cell compares its
// slot in parallel for find and delete; in the apply state the hits are resolved and the row shifts.
// A new word is taken only after the last one has left the apply state.
// Reset empties the list at once; slot contents are not cleared.
// A stalled result holds the apply cycle until the output register frees up.
module indexed_shift_list #(
    parameter int DEPTH      = isl_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = isl_pkg::ELEM_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    isl_in_if.sink                      i_in,
    isl_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [isl_pkg::CNT_W-1:0]   i_cfg_wdata
);

    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > isl_pkg::POS_W) ? LW : isl_pkg::POS_W;
    localparam int IW = $clog2(DEPTH);

    isl_pkg::t_state            r_state;
    isl_pkg::t_state            n_state;
    logic [LW-1:0]              r_len;
    logic [LW-1:0]              n_len;
    logic [isl_pkg::CNT_W-1:0]  r_cap;
    isl_pkg::t_func             r_func;
    logic [isl_pkg::POS_W-1:0]  r_pos;
    logic [ELEM_WIDTH-1:0]      r_val;

    logic                             r_out_valid;
    logic                             r_ok;
    logic [isl_pkg::VAL_W-1:0]        r_vout;
    logic [isl_pkg::POS_W-1:0]        r_fat;
    logic [isl_pkg::CNT_W-1:0]        r_cnt;
    logic                             n_ok;
    logic [isl_pkg::VAL_W-1:0]        n_vout;
    logic [isl_pkg::POS_W-1:0]        n_fat;

    logic                   w_accept;
    logic                   w_advance;
    logic [63:0]            w_in_wide;
    logic [ELEM_WIDTH-1:0]  w_in_elem;
    isl_pkg::t_cell_act     w_act;
    logic [CW-1:0]          w_pos;
    logic [CW-1:0]          w_len;
    logic [CW-1:0]          w_cap;
    logic [ELEM_WIDTH-1:0]  w_value;
    logic                   w_not_full;
    logic                   w_any_hit;
    logic [IW-1:0]          w_idx;
    logic [CW-1:0]          w_idx_ext;
    logic [ELEM_WIDTH-1:0]  w_sel;
    logic [63:0]            w_sel_wide;
    logic [CW-1:0]          w_len_ext;

    logic [ELEM_WIDTH-1:0]  w_data [DEPTH];
    logic [DEPTH-1:0]       w_hit;

    assign w_accept  = i_in.valid && i_in.ready;
    assign w_advance = (r_state == isl_pkg::ST_APPLY) && (!r_out_valid || o_out.ready);
    assign i_in.ready = (r_state == isl_pkg::ST_IDLE);

    assign w_in_wide = 64'(i_in.value_in);
    assign w_in_elem = w_in_wide[ELEM_WIDTH-1:0];

    assign w_len = CW'(r_len);
    assign w_cap = CW'(r_cap);
    assign w_not_full = (w_len < w_cap) && (w_len < CW'(DEPTH));
    assign w_any_hit  = |w_hit;

    // Lowest hit wins; for delete at most one cell is flagged.
    always_comb begin
        w_idx = '0;
        w_sel = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                w_idx = IW'(k);
            end
        end
        for (int k = 0; k < DEPTH; k++) begin
            w_sel = w_sel | (w_data[k] & {ELEM_WIDTH{w_hit[k]}});
        end
    end

    assign w_idx_ext  = CW'(w_idx);
    assign w_sel_wide = 64'(w_sel);

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_ok    = 1'b0;
        n_vout  = '0;
        n_fat   = isl_pkg::NO_POS;
        w_act   = isl_pkg::ACT_IDLE;
        w_pos   = CW'(r_pos);
        w_value = r_val;
        case (r_state)
            isl_pkg::ST_IDLE: begin
                w_pos   = CW'(i_in.position);
                w_value = w_in_elem;
                if (w_accept) begin
                    n_state = isl_pkg::ST_APPLY;
                    if (isl_pkg::t_func'(i_in.func) == isl_pkg::FN_FIND) begin
                        w_act = isl_pkg::ACT_CMP_FIND;
                    end else if (isl_pkg::t_func'(i_in.func) == isl_pkg::FN_DELETE) begin
                        w_act = isl_pkg::ACT_CMP_POS;
                    end
                end
            end
            isl_pkg::ST_APPLY: begin
                case (r_func)
                    isl_pkg::FN_PUSH: begin
                        n_ok = w_not_full;
                        if (n_ok) begin
                            w_act = isl_pkg::ACT_PUSH;
                            n_len = r_len + LW'(1);
                        end
                    end
                    isl_pkg::FN_INSERT: begin
                        n_ok = w_not_full && (w_pos <= w_len);
                        if (n_ok) begin
                            w_act = isl_pkg::ACT_INSERT;
                            n_len = r_len + LW'(1);
                        end
                    end
                    isl_pkg::FN_DELETE: begin
                        n_ok = w_any_hit;
                        if (n_ok) begin
                            w_act  = isl_pkg::ACT_DELETE;
                            n_len  = r_len - LW'(1);
                            n_vout = w_sel_wide[isl_pkg::VAL_W-1:0];
                        end
                    end
                    isl_pkg::FN_FIND: begin
                        n_ok = w_any_hit;
                        if (n_ok) begin
                            n_fat = w_idx_ext[isl_pkg::POS_W-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
                if (w_advance) begin
                    n_state = isl_pkg::ST_IDLE;
                end else begin
                    w_act = isl_pkg::ACT_IDLE;
                    n_len = r_len;
                end
            end
            default: begin
                n_state = isl_pkg::ST_IDLE;
            end
        endcase
    end

    assign w_len_ext = CW'(n_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= isl_pkg::ST_IDLE;
            r_len       <= '0;
            r_cap       <= isl_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= isl_pkg::t_func'(i_in.func);
            r_pos  <= i_in.position;
            r_val  <= w_in_elem;
        end
        if (w_advance) begin
            r_ok   <= n_ok;
            r_vout <= n_vout;
            r_fat  <= n_fat;
            r_cnt  <= w_len_ext[isl_pkg::CNT_W-1:0];
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.ok        = r_ok;
    assign o_out.value_out = r_vout;
    assign o_out.found_at  = r_fat;
    assign o_out.count     = r_cnt;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ELEM_WIDTH-1:0] w_left;
        logic [ELEM_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_data[g];
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        isl_cell #(
            .CW         (CW),
            .ELEM_WIDTH (ELEM_WIDTH),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_act   (w_act),
            .i_pos   (w_pos),
            .i_len   (w_len),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_hit   (w_hit[g])
        );
    end

    // The list can never hold more elements than it has cells.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_len) <= CW'(DEPTH))
        else $error("list length beyond depth");

    // A delete position selects at most one cell.
    a_del_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == isl_pkg::ST_APPLY && r_func == isl_pkg::FN_DELETE) |-> $onehot0(w_hit))
        else $error("delete flagged more than one cell");

    // An accepted word always goes to the apply cycle next.
    a_accept_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == isl_pkg::ST_APPLY))
        else $error("accepted word not applied");

    // The length only moves when a result is produced.
    a_len_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_len))
        else $error("length changed without a result");

endmodule

// ===== tb/isl_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for the indexed shift list: list model, queue of expected results, comparison.
module isl_list_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    isl_in_if                         op_mon,
    isl_out_if                        res_mon,
    input  logic                      i_cfg_we,
    input  logic [isl_pkg::CNT_W-1:0] i_cfg_wdata,
    output int                        o_in_flight,
    output int                        o_fail_count
);

    localparam int DEPTH = isl_pkg::DEPTH_DEF;
    localparam int VAL_W = isl_pkg::VAL_W;
    localparam int POS_W = isl_pkg::POS_W;
    localparam int CNT_W = isl_pkg::CNT_W;

    typedef struct packed {
        logic                    ok;
        logic [VAL_W-1:0]        value_out;
        logic signed [POS_W-1:0] found_at;
        logic [CNT_W-1:0]        count;
    } t_list_result;

    logic [VAL_W-1:0] list_slots [DEPTH];
    logic [CNT_W-1:0] list_len;
    logic [CNT_W-1:0] cap_limit;
    t_list_result     expected_results [$];
    int               n_fail = 0;

    assign o_fail_count = n_fail;

    // Applies one operation to the model list and returns the result word it yields.
    function automatic t_list_result apply_list_op(isl_pkg::t_func fn, logic [POS_W-1:0] pos,
                                                   logic [VAL_W-1:0] val);
        t_list_result res;
        int           cap_eff;
        int           i;
        res.ok        = 1'b0;
        res.value_out = '0;
        res.found_at  = isl_pkg::NO_POS;
        cap_eff = (int'(cap_limit) < DEPTH) ? int'(cap_limit) : DEPTH;
        case (fn)
            isl_pkg::FN_PUSH: begin
                if (int'(list_len) < cap_eff) begin
                    list_slots[list_len] = val;
                    list_len = list_len + 1'b1;
                    res.ok = 1'b1;
                end
            end
            isl_pkg::FN_INSERT: begin
                if (int'(list_len) < cap_eff && pos <= list_len) begin
                    for (i = int'(list_len); i > int'(pos); i--) begin
                        list_slots[i] = list_slots[i-1];
                    end
                    list_slots[pos] = val;
                    list_len = list_len + 1'b1;
                    res.ok = 1'b1;
                end
            end
            isl_pkg::FN_DELETE: begin
                if (pos < list_len) begin
                    res.value_out = list_slots[pos];
                    for (i = int'(pos); i + 1 < int'(list_len); i++) begin
                        list_slots[i] = list_slots[i+1];
                    end
                    list_len = list_len - 1'b1;
                    res.ok = 1'b1;
                end
            end
            default: begin
                for (i = 0; i < int'(list_len); i++) begin
                    if (!res.ok && list_slots[i] == val) begin
                        res.ok       = 1'b1;
                        res.found_at = POS_W'(i);
                    end
                end
            end
        endcase
        res.count = list_len;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            list_len  = '0;
            cap_limit = isl_pkg::CAP_RESET;
            expected_results.delete();
            o_in_flight <= 0;
        end else begin
            if (i_cfg_we) begin
                cap_limit = i_cfg_wdata;
            end
            if (op_mon.valid && op_mon.ready) begin
                expected_results.push_back(apply_list_op(isl_pkg::t_func'(op_mon.func),
                                                         op_mon.position, op_mon.value_in));
            end
            if (res_mon.valid && res_mon.ready) begin
                got.ok        = res_mon.ok;
                got.value_out = res_mon.value_out;
                got.found_at  = res_mon.found_at;
                got.count     = res_mon.count;
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected");
                    n_fail++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.ok !== want.ok) begin
                        $error("ok: expected %0d, actual %0d", want.ok, got.ok);
                        n_fail++;
                    end
                    if (got.value_out !== want.value_out) begin
                        $error("value_out: expected %h, actual %h", want.value_out,
                               got.value_out);
                        n_fail++;
                    end
                    if (got.found_at !== want.found_at) begin
                        $error("found_at: expected %0d, actual %0d", want.found_at,
                               got.found_at);
                        n_fail++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, got.count);
                        n_fail++;
                    end
                end
            end
            o_in_flight <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the indexed shift list: clock, reset, stimulus and verdict.
module tb_top;

    localparam int RANDOM_ITEMS = 1550;
    localparam int PHASES       = 8;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int POS_W        = isl_pkg::POS_W;
    localparam int VAL_W        = isl_pkg::VAL_W;
    localparam int CNT_W        = isl_pkg::CNT_W;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    bit               calm = 1'b0;
    int               in_flight;
    int               fail_count;
    int               quiet_cycles = 0;
    logic [VAL_W-1:0] value_pool [8];

    isl_in_if  op_ch ();
    isl_out_if res_ch ();

    indexed_shift_list u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (op_ch),
        .o_out       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    isl_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .op_mon       (op_ch),
        .res_mon      (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_in_flight  (in_flight),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 32);
    end

    // Ends the run if no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[indexed_shift_list] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(isl_pkg::t_func fn, logic [POS_W-1:0] pos,
                             logic [VAL_W-1:0] val);
        while (!calm && $urandom_range(0, 99) < 32) begin
            op_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        op_ch.valid    <= 1'b1;
        op_ch.func     <= fn;
        op_ch.position <= pos;
        op_ch.value_in <= val;
        do @(posedge i_clk); while (!op_ch.ready);
    endtask

    task automatic drain_results();
        op_ch.valid <= 1'b0;
        do @(posedge i_clk); while (in_flight != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] cap);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Growing stretches fill the list up to its capacity; shrinking ones empty it.
    task automatic send_random_word(bit grow);
        int               roll;
        isl_pkg::t_func   fn;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        roll = $urandom_range(0, 99);
        if (grow) begin
            fn = (roll < 35) ? isl_pkg::FN_PUSH : (roll < 70) ? isl_pkg::FN_INSERT :
                 (roll < 80) ? isl_pkg::FN_DELETE : isl_pkg::FN_FIND;
        end else begin
            fn = (roll < 10) ? isl_pkg::FN_PUSH : (roll < 20) ? isl_pkg::FN_INSERT :
                 (roll < 75) ? isl_pkg::FN_DELETE : isl_pkg::FN_FIND;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            pos = POS_W'($urandom_range(0, 8));
        end else if (roll < 88) begin
            pos = POS_W'($urandom_range(0, 16));
        end else begin
            pos = POS_W'($urandom_range(0, 31));
        end
        // Values mostly come from a small pool so that finds hit and duplicates occur.
        if ($urandom_range(0, 99) < 70) begin
            val = value_pool[$urandom_range(0, 7)];
        end else begin
            val = $urandom;
        end
        if ($urandom_range(0, 99) < 3) begin
            value_pool[$urandom_range(2, 7)] = $urandom;
        end
        send_word(fn, pos, val);
    endtask

    initial begin
        int phase_caps [PHASES];
        phase_caps     = '{16, 31, 3, 1, 15, 0, 0, 16};
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        op_ch.valid    = 1'b0;
        op_ch.func     = isl_pkg::FN_PUSH;
        op_ch.position = '0;
        op_ch.value_in = '0;
        value_pool[0]  = '0;
        value_pool[1]  = '1;
        for (int k = 2; k < 8; k++) begin
            value_pool[k] = $urandom;
        end
        phase_caps[5] = $urandom_range(0, 31);
        phase_caps[6] = $urandom_range(0, 31);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_capacity(5'd16);
        send_word(isl_pkg::FN_FIND,   5'd0,  32'h0000_0000);
        send_word(isl_pkg::FN_DELETE, 5'd0,  32'h0000_0000);
        send_word(isl_pkg::FN_INSERT, 5'd1,  32'h1111_1111);
        send_word(isl_pkg::FN_INSERT, 5'd0,  32'hFFFF_FFFF);
        send_word(isl_pkg::FN_PUSH,   5'd31, 32'h0000_0000);
        send_word(isl_pkg::FN_PUSH,   5'd0,  32'h1234_5678);
        send_word(isl_pkg::FN_INSERT, 5'd3,  32'hA5A5_A5A5);
        send_word(isl_pkg::FN_INSERT, 5'd1,  32'h5A5A_5A5A);
        send_word(isl_pkg::FN_FIND,   5'd0,  32'h1234_5678);
        send_word(isl_pkg::FN_FIND,   5'd0,  32'hA5A5_A5A5);
        send_word(isl_pkg::FN_FIND,   5'd0,  32'hFFFF_FFFF);
        send_word(isl_pkg::FN_FIND,   5'd0,  32'hDEAD_BEEF);
        send_word(isl_pkg::FN_DELETE, 5'd31, 32'h0000_0000);
        send_word(isl_pkg::FN_DELETE, 5'd5,  32'h0000_0000);
        send_word(isl_pkg::FN_DELETE, 5'd4,  32'h0000_0000);
        send_word(isl_pkg::FN_DELETE, 5'd0,  32'h0000_0000);

        // Capacity lowered below the current length: only delete and find succeed.
        write_capacity(5'd2);
        send_word(isl_pkg::FN_PUSH,   5'd0,  32'h0BAD_0BAD);
        send_word(isl_pkg::FN_INSERT, 5'd0,  32'h0BAD_0BAD);
        send_word(isl_pkg::FN_DELETE, 5'd1,  32'h0000_0000);
        send_word(isl_pkg::FN_PUSH,   5'd0,  32'h0BAD_0BAD);
        send_word(isl_pkg::FN_FIND,   5'd0,  32'h0000_0000);

        write_capacity(5'd0);
        send_word(isl_pkg::FN_PUSH,   5'd0,  32'hC0DE_C0DE);
        send_word(isl_pkg::FN_DELETE, 5'd0,  32'h0000_0000);
        send_word(isl_pkg::FN_DELETE, 5'd0,  32'h0000_0000);
        send_word(isl_pkg::FN_FIND,   5'd0,  32'h0000_0000);

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_caps[p][CNT_W-1:0]);
            calm <= (p == 2);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                send_random_word(((n / 24) % 2) == 0);
            end
        end

        drain_results();
        if (fail_count == 0 && in_flight == 0) begin
            $display("[indexed_shift_list] OK");
        end else begin
            $display("[indexed_shift_list] ERROR");
        end
        $finish;
    end

endmodule
